@@ rtl/nddi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nddi_pkg
// Shared types and constants for the Newton divided-difference core.
// ---------------------------------------------------------------------------
package nddi_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int DATA_W         = 32;
  localparam int FRAC_W         = 16;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;

  // divider: dividend |num| << 16 fits 49 bits, divisor |den| fits 33 bits
  localparam int DVD_W = 49;
  localparam int DVS_W = 33;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_REPEAT = 3'd2,
    ST_SAT    = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

endpackage

`default_nettype wire

@@ rtl/nddi_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nddi_req_if
// Request channel: load a sample point or evaluate at a query abscissa.
// ---------------------------------------------------------------------------
interface nddi_req_if
  import nddi_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [DATA_W-1:0] sample_x;
  logic signed [DATA_W-1:0] sample_y;
  logic signed [DATA_W-1:0] query_x;

  modport source (output valid, req_type, sample_x, sample_y, query_x, input ready);
  modport sink   (input valid, req_type, sample_x, sample_y, query_x, output ready);
endinterface

`default_nettype wire

@@ rtl/nddi_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nddi_rsp_if
// Response channel: interpolated value and status word.
// ---------------------------------------------------------------------------
interface nddi_rsp_if
  import nddi_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] interp_value;
  logic [2:0]               status;

  modport source (output valid, interp_value, status, input ready);
  modport sink   (input valid, interp_value, status, output ready);
endinterface

`default_nettype wire

@@ rtl/nddi_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nddi_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module nddi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/nddi_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nddi_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module nddi_div
  import nddi_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  logic              busy;
  logic [DCNT_W-1:0] ctr;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W:0]    trial;
  logic              fits;

  assign trial = {rem, quotient[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ctr  <= '0;
    end else begin
      done <= busy && (ctr == DCNT_W'(1));
      if (start) begin
        busy     <= 1'b1;
        ctr      <= DCNT_W'(DVD_W);
        dvs      <= divisor;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], fits};
        ctr      <= ctr - DCNT_W'(1);
        if (ctr == DCNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/newton_divided_difference_interp_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// newton_divided_difference_interp_core
// Newton divided-difference interpolation over up to MAX_POINTS samples.
// ---------------------------------------------------------------------------
// Usage:
//   request : one word per item. req_type 0 appends (sample_x, sample_y),
//             signed Q16.16, to the point set; req_type 1 evaluates the
//             Newton form at query_x and then empties the set.
//   response: exactly one word per request (interp_value, status).
// Sequence:
//   load     : result registered, valid the cycle after acceptance.
//   evaluate : up to (n-1)*n/2 coefficient steps, each the read states
//              S_R1 to S_R3 plus the bit-serial divider, then states
//              S_E2 to S_E6 for each term of the Newton form. The
//              divider sets the rate.
// Throughput: one item at a time; request.ready is high only while the
//   sequencer is idle and the output register is free or being drained.
// Stores: x values and coefficients sit in two small RAMs; only entries
//   below the point count are ever read, so no clearing pass is needed.
// Reset: point count cleared, sequencer idle, no response pending.
// Stall: a stalled response holds the output register; a finished
//   evaluation waits in the sequencer until the register frees.
// ---------------------------------------------------------------------------
module newton_divided_difference_interp_core
  import nddi_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  nddi_req_if.sink   request,
  nddi_rsp_if.source response
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_R1, S_R2, S_R3, S_DIV, S_E0, S_E1, S_E2, S_E3, S_E4, S_E5,
    S_E6, S_FIN
  } state_t;

  state_t state;

  logic [CW-1:0] point_count;
  logic [CW-1:0] n_pts;
  logic [CW-1:0] j;
  logic [IW-1:0] i;

  logic signed [DATA_W-1:0] qx, xi, ci, cj, term, result;
  logic signed [64:0]       prod;
  logic                     sat;
  logic                     qneg;
  logic [2:0]               res_status;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic [2:0]               out_status;
  logic                     out_free;

  // RAM ports
  logic              x_we, c_we;
  logic [IW-1:0]     x_waddr, c_waddr, x_raddr, c_raddr;
  logic [DATA_W-1:0] x_wdata, c_wdata, x_rdata, c_rdata;

  // divider
  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dvd, div_q;
  logic [DVS_W-1:0]  div_dvs;

  nddi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_xram (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(x_raddr), .rdata(x_rdata)
  );

  nddi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_cram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  nddi_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_q)
  );

  // saturation helpers on a 65-bit signed value
  function automatic logic ovf32(input logic signed [64:0] v);
    return (v > 65'sd2147483647) || (v < -65'sd2147483648);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Q16.16 rescale with truncation toward zero
  function automatic logic signed [64:0] rescale(input logic signed [64:0] v);
    logic signed [64:0] adj;
    adj = v + (v[64] ? 65'sd65535 : 65'sd0);
    return adj >>> FRAC_W;
  endfunction

  logic accept;
  logic out_load;
  assign out_free      = !out_valid || response.ready;
  assign request.ready = (state == S_IDLE) && out_free;
  assign accept        = request.valid && request.ready;

  // a new result word enters the output register this cycle
  assign out_load = ((state == S_IDLE) && accept &&
                     (!request.req_type || (point_count == '0))) ||
                    ((state == S_FIN) && out_free);

  assign response.valid        = out_valid;
  assign response.interp_value = out_value;
  assign response.status       = out_status;

  // coefficient step operands (data of the second read)
  logic signed [32:0] den, num;
  logic signed [48:0] num_sh;
  assign den    = 33'(xi) - 33'(signed'(x_rdata));
  assign num    = 33'(ci) - 33'(signed'(c_rdata));
  assign num_sh = 49'(num) <<< FRAC_W;

  assign div_start = (state == S_R3) && (den != '0);
  assign div_dvd   = num_sh[48] ? DVD_W'(-num_sh) : DVD_W'(num_sh);
  assign div_dvs   = den[32] ? DVS_W'(-den) : DVS_W'(den);

  // signed quotient; clamped when written to the coefficient store
  logic signed [64:0] qsig;
  assign qsig = qneg ? -65'(signed'({1'b0, div_q})) : 65'(signed'({1'b0, div_q}));

  // evaluation operands
  logic signed [32:0] dq;
  logic signed [64:0] prod_s, sum_s;
  assign dq     = 33'(qx) - 33'(signed'(x_rdata));
  assign prod_s = rescale(prod);
  assign sum_s  = prod_s + 65'(result);

  always_comb begin
    x_we    = 1'b0;
    c_we    = 1'b0;
    x_waddr = point_count[IW-1:0];
    c_waddr = point_count[IW-1:0];
    x_wdata = request.sample_x;
    c_wdata = request.sample_y;
    x_raddr = i;
    c_raddr = i;
    case (state)
      S_IDLE: begin
        if (accept && !request.req_type && (point_count < CW'(MAX_POINTS))) begin
          x_we = 1'b1;
          c_we = 1'b1;
        end
      end
      S_R2: begin
        x_raddr = i - j[IW-1:0];
        c_raddr = i - IW'(1);
      end
      S_DIV: begin
        c_we    = div_done;
        c_waddr = i;
        c_wdata = clamp32(qsig);
      end
      S_E0: begin
        c_raddr = '0;
      end
      S_E2: begin
        x_raddr = j[IW-1:0] - IW'(1);
        c_raddr = j[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (response.valid && response.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!request.req_type) begin
              out_valid <= 1'b1;
              out_value <= '0;
              if (point_count < CW'(MAX_POINTS)) begin
                point_count <= point_count + CW'(1);
                out_status  <= ST_OK;
              end else begin
                out_status <= ST_FULL;
              end
            end else if (point_count == '0) begin
              out_valid  <= 1'b1;
              out_value  <= '0;
              out_status <= ST_EMPTY;
            end else begin
              qx    <= request.query_x;
              n_pts <= point_count;
              sat   <= 1'b0;
              j     <= CW'(1);
              i     <= IW'(point_count - CW'(1));
              state <= (point_count == CW'(1)) ? S_E0 : S_R1;
            end
          end
        end
        S_R1: state <= S_R2;
        S_R2: begin
          xi    <= x_rdata;
          ci    <= c_rdata;
          state <= S_R3;
        end
        S_R3: begin
          if (den == '0) begin
            result     <= '0;
            res_status <= ST_REPEAT;
            state      <= S_FIN;
          end else begin
            qneg  <= num[32] ^ den[32];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (ovf32(qsig)) begin
              sat <= 1'b1;
            end
            if (CW'(i) == j) begin
              if (j + CW'(1) == n_pts) begin
                state <= S_E0;
              end else begin
                j     <= j + CW'(1);
                i     <= IW'(n_pts - CW'(1));
                state <= S_R1;
              end
            end else begin
              i     <= i - IW'(1);
              state <= S_R1;
            end
          end
        end
        S_E0: begin
          term  <= Q_ONE;
          j     <= CW'(1);
          state <= S_E1;
        end
        S_E1: begin
          result <= c_rdata;
          if (n_pts == CW'(1)) begin
            res_status <= ST_OK;
            state      <= S_FIN;
          end else begin
            state <= S_E2;
          end
        end
        S_E2: state <= S_E3;
        S_E3: begin
          prod  <= 65'(term) * 65'(dq);
          cj    <= c_rdata;
          state <= S_E4;
        end
        S_E4: begin
          term <= clamp32(prod_s);
          if (ovf32(prod_s)) begin
            sat <= 1'b1;
          end
          state <= S_E5;
        end
        S_E5: begin
          prod  <= 65'(cj) * 65'(term);
          state <= S_E6;
        end
        S_E6: begin
          result <= clamp32(sum_s);
          if (ovf32(sum_s)) begin
            sat <= 1'b1;
          end
          if (j + CW'(1) == n_pts) begin
            res_status <= (sat || ovf32(sum_s)) ? ST_SAT : ST_OK;
            state      <= S_FIN;
          end else begin
            j     <= j + CW'(1);
            state <= S_E2;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_value   <= result;
            out_status  <= res_status;
            point_count <= '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // point count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");

  // the divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider result with sequencer elsewhere");

  // an evaluation always leaves the point set empty
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> point_count == '0)
    else $error("point set not cleared after evaluation");

endmodule

`default_nettype wire
